### hdl/pstk_pkg.sv
// Shared types and constants for the priority stack block.
// No dependencies; every other file imports this package.
package pstk_pkg;

    localparam int CAPACITY   = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int PRIO_WIDTH = 8;
    localparam int CNT_WIDTH  = $clog2(CAPACITY + 1);

    // request codes (code 3 behaves as a query)
    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [ELEM_WIDTH-1:0] elem_in;
        logic [PRIO_WIDTH-1:0] prio_in;
    } req_word_t;

    typedef struct packed {
        logic [ELEM_WIDTH-1:0] head_elem;
        logic [PRIO_WIDTH-1:0] head_prio;
        logic [CNT_WIDTH-1:0]  entry_count;
        logic                  is_empty;
        logic [1:0]            status;
    } rsp_word_t;

    typedef enum logic [0:0] {
        FSM_IDLE,
        FSM_EXEC
    } fsm_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture the accepted request word
        logic exec;   // apply it to the cells and load the result register
    } pstk_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic rsp_free;  // result register empty or being taken this cycle
    } pstk_sts_t;

endpackage

### hdl/pstk_ctrl.sv
// Controller FSM for the priority stack: sequences capture and update.
// Depends on pstk_pkg.
module pstk_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  pstk_pkg::pstk_sts_t sts,
    output pstk_pkg::pstk_cmd_t cmd
);
    import pstk_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        cmd        = '0;
        unique case (state_reg)
            FSM_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                // wait here only while an old result is still held
                if (sts.rsp_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

### hdl/pstk_dpath.sv
// Datapath for the priority stack: sorted cell row, request and result registers.
// Depends on pstk_pkg.
module pstk_dpath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pstk_pkg::req_word_t  req_word,
    input  pstk_pkg::pstk_cmd_t  cmd,
    output pstk_pkg::pstk_sts_t  sts,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output pstk_pkg::rsp_word_t  rsp_word
);
    import pstk_pkg::*;

    req_word_t             req_reg;
    logic [ELEM_WIDTH-1:0] elem_reg  [CAPACITY];
    logic [ELEM_WIDTH-1:0] elem_next [CAPACITY];
    logic [PRIO_WIDTH-1:0] prio_reg  [CAPACITY];
    logic [PRIO_WIDTH-1:0] prio_next [CAPACITY];
    logic [CNT_WIDTH-1:0]  count_reg;
    logic [CNT_WIDTH-1:0]  count_next;
    logic [CAPACITY-1:0]   stay;
    logic [CAPACITY-1:0]   ins;
    logic [1:0]            status;
    rsp_word_t             rsp_reg;
    rsp_word_t             rsp_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;

    // cells holding a strictly higher priority keep their place on push
    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            stay[k] = (CNT_WIDTH'(k) < count_reg) && (prio_reg[k] > req_reg.prio_in);
        end
        ins[0] = !stay[0];
        for (int k = 1; k < CAPACITY; k++)
        begin
            ins[k] = !stay[k] && stay[k-1];
        end
    end

    always_comb
    begin
        elem_next  = elem_reg;
        prio_next  = prio_reg;
        count_next = count_reg;
        status     = ST_OK;
        unique case (req_reg.req_type)
            REQ_PUSH:
            begin
                if (count_reg == CNT_WIDTH'(CAPACITY))
                begin
                    status = ST_PUSH_FULL;
                end
                else
                begin
                    for (int k = 1; k < CAPACITY; k++)
                    begin
                        if (!stay[k])
                        begin
                            elem_next[k] = elem_reg[k-1];
                            prio_next[k] = prio_reg[k-1];
                        end
                    end
                    for (int k = 0; k < CAPACITY; k++)
                    begin
                        if (ins[k])
                        begin
                            elem_next[k] = req_reg.elem_in;
                            prio_next[k] = req_reg.prio_in;
                        end
                    end
                    count_next = count_reg + CNT_WIDTH'(1);
                end
            end
            REQ_POP:
            begin
                if (count_reg == '0)
                begin
                    status = ST_POP_EMPTY;
                end
                else
                begin
                    for (int k = 0; k < CAPACITY - 1; k++)
                    begin
                        elem_next[k] = elem_reg[k+1];
                        prio_next[k] = prio_reg[k+1];
                    end
                    count_next = count_reg - CNT_WIDTH'(1);
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        rsp_next.head_elem   = (count_next != '0) ? elem_next[0] : '0;
        rsp_next.head_prio   = (count_next != '0) ? prio_next[0] : '0;
        rsp_next.entry_count = count_next;
        rsp_next.is_empty    = (count_next == '0);
        rsp_next.status      = status;
    end

    assign rsp_valid_next = cmd.exec || (rsp_valid_reg && rsp_stall);
    assign sts.rsp_free   = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (cmd.exec)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_word;
        end
        if (cmd.exec)
        begin
            elem_reg <= elem_next;
            prio_reg <= prio_next;
            rsp_reg  <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

endmodule

### hdl/priority_stack_sorted_insert.sv
// Top level of the bounded priority stack.
// Depends on pstk_pkg, pstk_ctrl and pstk_dpath.
//
// Bounded priority stack of CAPACITY entries (16), kept sorted by
// descending priority with the head in cell 0. A push inserts in front of
// the first entry whose priority is less than or equal to the new one, so
// equal priorities come out newest first. A pop drops the head, a query
// (and the unused code 3) leaves the stack alone. Each request word yields
// exactly one result word: head element and priority (zero when empty),
// entry count, empty flag and status (push on full dropped, pop on empty
// ignored). A request is first captured into the request register; then
// all cells compare against the new priority in parallel and shift or
// load in place, and the result lands in an output register. A new
// request is accepted while an older result is still held there, but only
// after the previous request has updated the cells; its update waits
// while the output side stalls. No clearing pass after reset: cells above
// the count are never read.
module priority_stack_sorted_insert
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  pstk_pkg::req_word_t req_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output pstk_pkg::rsp_word_t rsp_word
);
    import pstk_pkg::*;

    pstk_cmd_t cmd;
    pstk_sts_t sts;

    // sequencing: idle -> capture -> update
    pstk_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // sorted cell row and result register
    pstk_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (req_word),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule

### hdl/pstk_checker.sv
// Port-level checks for the priority stack, bound to the top level.
// Depends on pstk_pkg and priority_stack_sorted_insert.
module pstk_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input pstk_pkg::rsp_word_t rsp_word
);
    import pstk_pkg::*;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_word.entry_count <= CNT_WIDTH'(CAPACITY)))
        else $error("entry count above capacity");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_word.is_empty == (rsp_word.entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_word.is_empty)
            |-> (rsp_word.head_elem == '0 && rsp_word.head_prio == '0))
        else $error("nonzero head on empty stack");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_word.status == ST_PUSH_FULL)
            |-> (rsp_word.entry_count == CNT_WIDTH'(CAPACITY)))
        else $error("push dropped while not full");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
        else $error("stalled result word changed");

endmodule

bind priority_stack_sorted_insert pstk_checker u_pstk_checker (.*);
